FILE: design/bitmap_glyph_blitter_assert.svh
// assertion macros for the bitmap glyph blitter checker
// expects signals named clk and rst in the scope where a macro is used
`ifndef BITMAP_GLYPH_BLITTER_ASSERT_SVH
`define BITMAP_GLYPH_BLITTER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BGB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BGB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/bgb_pkg.sv
// shared types and constants of the bitmap glyph blitter
// no dependencies
package bgb_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GLYPH_COUNT  = 3'd2;
  localparam logic [2:0] REG_GLYPH_BYTES  = 3'd3;
  localparam logic [2:0] REG_HEADER_BYTES = 3'd4;
  localparam logic [2:0] REG_LINE_PITCH   = 3'd5;
  localparam logic [2:0] REG_FB_BASE      = 3'd6;

  // register reset values
  localparam logic [4:0]  RST_GLYPH_WIDTH  = 5'd8;
  localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [9:0]  RST_GLYPH_COUNT  = 10'd256;
  localparam logic [6:0]  RST_GLYPH_BYTES  = 7'd16;
  localparam logic [7:0]  RST_HEADER_BYTES = 8'd32;
  localparam logic [15:0] RST_LINE_PITCH   = 16'd4096;
  localparam logic [31:0] RST_FB_BASE      = 32'd0;

  // pixels per row byte and framebuffer bytes per segment
  localparam int unsigned SEG_PIXELS = 8;
  localparam logic [31:0] SEG_STRIDE = 32'd32;

  // width of a store address before wrapping (header plus glyph offset)
  localparam int unsigned RED_W = 17;

  typedef struct packed {
    logic [4:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [9:0]  glyph_count;
    logic [6:0]  glyph_bytes;
    logic [7:0]  header_bytes;
    logic [15:0] line_pitch;
    logic [31:0] fb_base;
  } cfg_t;

  // one row segment on its way from the sequencer to the output stage
  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  cnt;
    logic        last;
    logic [31:0] fg;
    logic [31:0] bg;
  } seg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SETUP,
    ST_REDUCE,
    ST_WRITE,
    ST_EMIT
  } state_t;

endpackage

FILE: design/bgb_in_if.sv
// request channel of the bitmap glyph blitter: load and draw requests
// no dependencies
interface bgb_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] char_code;
  logic [9:0]  cell_x;
  logic [9:0]  cell_y;
  logic [31:0] fg_color;
  logic [31:0] bg_color;
  logic [14:0] store_address;
  logic [7:0]  store_byte;

  modport source (
    output valid, mode, char_code, cell_x, cell_y, fg_color, bg_color,
           store_address, store_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, char_code, cell_x, cell_y, fg_color, bg_color,
           store_address, store_byte,
    output ready
  );
endinterface

FILE: design/bgb_out_if.sv
// result channel of the bitmap glyph blitter: one row segment per transfer
// no dependencies
interface bgb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_address;
  logic [3:0]  pixel_count;
  logic [31:0] color_0;
  logic [31:0] color_1;
  logic [31:0] color_2;
  logic [31:0] color_3;
  logic [31:0] color_4;
  logic [31:0] color_5;
  logic [31:0] color_6;
  logic [31:0] color_7;
  logic        last_segment;

  modport source (
    output valid, pixel_address, pixel_count, color_0, color_1, color_2, color_3,
           color_4, color_5, color_6, color_7, last_segment,
    input  ready
  );
  modport sink (
    input  valid, pixel_address, pixel_count, color_0, color_1, color_2, color_3,
           color_4, color_5, color_6, color_7, last_segment,
    output ready
  );
endinterface

FILE: design/bgb_font_mem.sv
// font byte store: one write port, one read port, registered read data
// no dependencies
module bgb_font_mem #(
  parameter int unsigned DEPTH = 32768,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/bgb_seq.sv
// sequencer: takes requests, computes glyph and framebuffer addresses,
// wraps store addresses, writes loaded bytes and issues one store read per row segment
// depends on bgb_pkg and bgb_in_if
module bgb_seq #(
  parameter int unsigned STORE_BYTES = 32768,
  parameter int unsigned MAX_WIDTH   = 16,
  parameter int unsigned MAX_HEIGHT  = 32,
  localparam int unsigned AW = $clog2(STORE_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  bgb_in_if.sink          cmd,
  input  bgb_pkg::cfg_t   cfg,
  output logic            mem_we,
  output logic [AW-1:0]   mem_waddr,
  output logic [7:0]      mem_wdata,
  output logic            mem_re,
  output logic [AW-1:0]   mem_raddr,
  output bgb_pkg::seg_t   seg,
  input  logic            can_issue
);

  // conditional subtract steps that bring a RED_W-bit address below STORE_BYTES
  localparam int unsigned RED_SPAN  = 1 << bgb_pkg::RED_W;
  localparam int unsigned RED_CEIL  = $clog2((RED_SPAN + STORE_BYTES - 1) / STORE_BYTES);
  localparam int unsigned RED_STEPS = (RED_CEIL > 0) ? RED_CEIL : 1;
  localparam int unsigned STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam logic [AW-1:0] PTR_LAST = AW'(STORE_BYTES - 1);

  bgb_pkg::state_t state, state_next;

  logic                      is_load;
  logic [15:0]               code;
  logic [9:0]                cx;
  logic [9:0]                cy;
  logic [31:0]               fg;
  logic [31:0]               bg;
  logic [7:0]                sbyte;
  logic [4:0]                w;
  logic [5:0]                h;
  logic [16:0]               idxgb;
  logic [14:0]               cyh;
  logic [13:0]               cxw;
  logic [31:0]               cyhp;
  logic [bgb_pkg::RED_W-1:0] red_val;
  logic [bgb_pkg::RED_W-1:0] red_nxt;
  logic [STEP_W-1:0]         step;
  logic [AW-1:0]             ptr;
  logic [31:0]               row_addr;
  logic [5:0]                y;
  logic                      b;

  logic [4:0]  w_sat;
  logic [5:0]  h_sat;
  logic [9:0]  idx;
  logic [31:0] thresh;
  logic        last_byte;
  logic        issue;

  // saturated geometry and glyph index
  assign w_sat = (cfg.glyph_width > 5'(MAX_WIDTH)) ? 5'(MAX_WIDTH) : cfg.glyph_width;
  assign h_sat = (cfg.glyph_height > 6'(MAX_HEIGHT)) ? 6'(MAX_HEIGHT) : cfg.glyph_height;
  assign idx   = (code != 16'd0 && code < {6'd0, cfg.glyph_count}) ? code[9:0] : 10'd0;

  // one step of the store address wrap
  assign thresh  = 32'(STORE_BYTES) << step;
  assign red_nxt = ({15'd0, red_val} >= thresh) ?
                   (red_val - bgb_pkg::RED_W'(thresh)) : red_val;

  // second row byte exists only for glyphs wider than eight pixels
  assign last_byte = b || (w <= 5'd8);
  assign issue     = (state == bgb_pkg::ST_EMIT) && can_issue;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bgb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and outputs
  always_comb begin
    state_next = state;
    cmd.ready  = (state == bgb_pkg::ST_IDLE);
    mem_we     = (state == bgb_pkg::ST_WRITE);
    mem_waddr  = AW'(red_val);
    mem_wdata  = sbyte;
    mem_re     = issue;
    mem_raddr  = ptr;
    seg.addr   = row_addr + (b ? bgb_pkg::SEG_STRIDE : 32'd0);
    seg.cnt    = b ? 4'(w - 5'd8) : ((w > 5'd8) ? 4'd8 : w[3:0]);
    seg.last   = last_byte && (y == h - 6'd1);
    seg.fg     = fg;
    seg.bg     = bg;
    case (state)
      bgb_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          state_next = cmd.mode ? bgb_pkg::ST_MUL : bgb_pkg::ST_REDUCE;
        end
      end
      bgb_pkg::ST_MUL: begin
        if (w == 5'd0 || h == 6'd0) begin
          state_next = bgb_pkg::ST_IDLE;
        end else begin
          state_next = bgb_pkg::ST_SETUP;
        end
      end
      bgb_pkg::ST_SETUP: begin
        state_next = bgb_pkg::ST_REDUCE;
      end
      bgb_pkg::ST_REDUCE: begin
        if (step == '0) begin
          state_next = is_load ? bgb_pkg::ST_WRITE : bgb_pkg::ST_EMIT;
        end
      end
      bgb_pkg::ST_WRITE: begin
        state_next = bgb_pkg::ST_IDLE;
      end
      bgb_pkg::ST_EMIT: begin
        if (issue && seg.last) begin
          state_next = bgb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bgb_pkg::ST_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bgb_pkg::ST_IDLE: begin
        if (cmd.valid) begin
          is_load <= ~cmd.mode;
          code    <= cmd.char_code;
          cx      <= cmd.cell_x;
          cy      <= cmd.cell_y;
          fg      <= cmd.fg_color;
          bg      <= cmd.bg_color;
          sbyte   <= cmd.store_byte;
          w       <= w_sat;
          h       <= h_sat;
          red_val <= bgb_pkg::RED_W'(cmd.store_address);
          step    <= STEP_W'(RED_STEPS - 1);
        end
      end
      // glyph offset and cell position products
      bgb_pkg::ST_MUL: begin
        idxgb <= 17'(idx) * 17'(cfg.glyph_bytes);
        cyh   <= 15'(cy) * 15'(h);
        cxw   <= 14'(cx) * 14'(w);
      end
      bgb_pkg::ST_SETUP: begin
        red_val <= bgb_pkg::RED_W'(cfg.header_bytes) + idxgb;
        cyhp    <= 32'(cyh) * 32'(cfg.line_pitch);
        step    <= STEP_W'(RED_STEPS - 1);
      end
      // wrap the store address, build the framebuffer origin
      bgb_pkg::ST_REDUCE: begin
        red_val  <= red_nxt;
        step     <= step - STEP_W'(1);
        ptr      <= AW'(red_nxt);
        row_addr <= cfg.fb_base + cyhp + {16'd0, cxw, 2'b00};
        y        <= 6'd0;
        b        <= 1'b0;
      end
      // walk rows and row bytes, store pointer wraps at the end
      bgb_pkg::ST_EMIT: begin
        if (issue) begin
          ptr <= (ptr == PTR_LAST) ? '0 : ptr + AW'(1);
          if (last_byte) begin
            b        <= 1'b0;
            y        <= y + 6'd1;
            row_addr <= row_addr + 32'(cfg.line_pitch);
          end else begin
            b <= 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: design/bgb_emit.sv
// output stage: holds the segment whose store read is in flight and the
// result register, expands row bits into colors
// depends on bgb_pkg and bgb_out_if
module bgb_emit (
  input  logic          clk,
  input  logic          rst,
  input  logic          issue,
  input  bgb_pkg::seg_t seg,
  input  logic [7:0]    rdata,
  output logic          can_issue,
  bgb_out_if.source     pixels
);

  logic          pend_valid;
  bgb_pkg::seg_t pend;
  logic          out_valid;
  logic          move;
  logic [31:0]   color_next [bgb_pkg::SEG_PIXELS];
  logic [31:0]   color      [bgb_pkg::SEG_PIXELS];
  logic [31:0]   out_addr;
  logic [3:0]    out_cnt;
  logic          out_last;

  assign move      = pend_valid && (!out_valid || pixels.ready);
  assign can_issue = !pend_valid || move;

  // msb first, unused pixels read as zero
  always_comb begin
    for (int k = 0; k < bgb_pkg::SEG_PIXELS; k++) begin
      if (4'(k) < pend.cnt) begin
        color_next[k] = rdata[3'(7 - k)] ? pend.fg : pend.bg;
      end else begin
        color_next[k] = 32'd0;
      end
    end
  end

  // in-flight read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (issue) begin
      pend_valid <= 1'b1;
    end else if (move) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pend <= seg;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (pixels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_addr <= pend.addr;
      out_cnt  <= pend.cnt;
      out_last <= pend.last;
      color    <= color_next;
    end
  end

  assign pixels.valid         = out_valid;
  assign pixels.pixel_address = out_addr;
  assign pixels.pixel_count   = out_cnt;
  assign pixels.color_0       = color[0];
  assign pixels.color_1       = color[1];
  assign pixels.color_2       = color[2];
  assign pixels.color_3       = color[3];
  assign pixels.color_4       = color[4];
  assign pixels.color_5       = color[5];
  assign pixels.color_6       = color[6];
  assign pixels.color_7       = color[7];
  assign pixels.last_segment  = out_last;

endmodule

FILE: design/bitmap_glyph_blitter.sv
// load: the store address passes the wrap steps, then the byte is written
// draw: products, setup and the same wrap steps, then one row segment per cycle through the
// single store read port while the output stage takes them; height x (1 or 2) segments, 16
// for an 8x16 glyph, each via the result register; the next request is taken once the last
// read has gone out; reset: registers return to their defaults and the pipeline empties;
// the font store keeps its contents and needs no clearing pass
module bitmap_glyph_blitter #(
  parameter int unsigned STORE_BYTES = 32768,
  parameter int unsigned MAX_WIDTH   = 16,
  parameter int unsigned MAX_HEIGHT  = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  bgb_in_if.sink      cmd,
  bgb_out_if.source   pixels
);

  localparam int unsigned AW = $clog2(STORE_BYTES);

  bgb_pkg::cfg_t cfg;
  bgb_pkg::seg_t seg;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;
  logic          can_issue;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glyph_width  <= bgb_pkg::RST_GLYPH_WIDTH;
      cfg.glyph_height <= bgb_pkg::RST_GLYPH_HEIGHT;
      cfg.glyph_count  <= bgb_pkg::RST_GLYPH_COUNT;
      cfg.glyph_bytes  <= bgb_pkg::RST_GLYPH_BYTES;
      cfg.header_bytes <= bgb_pkg::RST_HEADER_BYTES;
      cfg.line_pitch   <= bgb_pkg::RST_LINE_PITCH;
      cfg.fb_base      <= bgb_pkg::RST_FB_BASE;
    end else if (cfg_write) begin
      case (cfg_index)
        bgb_pkg::REG_GLYPH_WIDTH:  cfg.glyph_width  <= cfg_data[4:0];
        bgb_pkg::REG_GLYPH_HEIGHT: cfg.glyph_height <= cfg_data[5:0];
        bgb_pkg::REG_GLYPH_COUNT:  cfg.glyph_count  <= cfg_data[9:0];
        bgb_pkg::REG_GLYPH_BYTES:  cfg.glyph_bytes  <= cfg_data[6:0];
        bgb_pkg::REG_HEADER_BYTES: cfg.header_bytes <= cfg_data[7:0];
        bgb_pkg::REG_LINE_PITCH:   cfg.line_pitch   <= cfg_data[15:0];
        bgb_pkg::REG_FB_BASE:      cfg.fb_base      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // request sequencing and address generation
  bgb_seq #(
    .STORE_BYTES (STORE_BYTES),
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .seg       (seg),
    .can_issue (can_issue)
  );

  // font store
  bgb_font_mem #(
    .DEPTH (STORE_BYTES)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // color expansion and result register
  bgb_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .issue     (mem_re),
    .seg       (seg),
    .rdata     (mem_rdata),
    .can_issue (can_issue),
    .pixels    (pixels)
  );

endmodule

FILE: design/bgb_checker.sv
// port-level checker for the bitmap glyph blitter, bound to the top level
// depends on bitmap_glyph_blitter_assert.svh
`include "bitmap_glyph_blitter_assert.svh"

module bgb_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        cmd_mode,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] res_pixel_address,
  input logic [3:0]  res_pixel_count,
  input logic [31:0] res_color_7,
  input logic        res_last_segment
);

  // a stalled result stays offered
  `BGB_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

  // a stalled result keeps its address and end mark
  `BGB_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_pixel_address) && $stable(res_last_segment), "stalled result changed")

  // a segment carries one to eight pixels
  `BGB_ASSERT_NOW(a_count_range, res_valid, res_pixel_count != 4'd0 && res_pixel_count <= 4'd8, "pixel count out of range")

  // the last pixel color is zero unless the segment is full
  `BGB_ASSERT_NOW(a_unused_zero, res_valid && res_pixel_count != 4'd8, res_color_7 == 32'd0, "unused pixel color not zero")

  // a load request occupies the sequencer for the address wrap
  `BGB_ASSERT_NEXT(a_load_busy, cmd_valid && cmd_ready && !cmd_mode, !cmd_ready, "request taken during store load")

endmodule

bind bitmap_glyph_blitter bgb_checker u_bgb_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .cmd_mode          (cmd.mode),
  .res_valid         (pixels.valid),
  .res_ready         (pixels.ready),
  .res_pixel_address (pixels.pixel_address),
  .res_pixel_count   (pixels.pixel_count),
  .res_color_7       (pixels.color_7),
  .res_last_segment  (pixels.last_segment)
);

FILE: dv/bgb_tb_pkg.sv
`timescale 1ns / 100ps
// request modes and store geometry shared by the blitter checker and testbench top
// depends on nothing; the block's own types come from bgb_pkg
package bgb_tb_pkg;

  // request modes on the command channel
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_DRAW = 1'b1;

  // font store depth and glyph size limits of the default build
  localparam int unsigned STORE_DEPTH      = 32768;
  localparam int unsigned GLYPH_MAX_WIDTH  = 16;
  localparam int unsigned GLYPH_MAX_HEIGHT = 32;

endpackage

FILE: dv/glyph_segment_checker.sv
`timescale 1ns / 100ps
// checker for the bitmap glyph blitter: mirrors registers and font store, expands each
// draw request into row segments and compares them; depends on bgb_pkg, bgb_tb_pkg and
// the bgb_in_if / bgb_out_if channel interfaces
module glyph_segment_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  bgb_in_if           cmd,
  bgb_out_if          pixels,
  output int unsigned mismatches,
  output int unsigned pending
);
  import bgb_pkg::*;
  import bgb_tb_pkg::*;

  typedef struct packed {
    logic [31:0]      address;
    logic [3:0]       count;
    logic [7:0][31:0] color;
    logic             last;
  } segment_t;

  logic [7:0] font_copy [STORE_DEPTH];
  cfg_t       regs;
  segment_t   segment_q [$];

  // expand one draw request into its row segments, in emission order
  function automatic void expand_glyph(input logic [15:0] code, input logic [9:0] cx,
                                       input logic [9:0] cy, input logic [31:0] fg,
                                       input logic [31:0] bg);
    logic [31:0] w, h, bpl, idx, glyph, origin, left, cnt;
    logic [7:0]  row;
    segment_t    s;
    int unsigned y, b, k;
    w = (32'(regs.glyph_width) > GLYPH_MAX_WIDTH) ? GLYPH_MAX_WIDTH : 32'(regs.glyph_width);
    h = (32'(regs.glyph_height) > GLYPH_MAX_HEIGHT) ? GLYPH_MAX_HEIGHT
                                                     : 32'(regs.glyph_height);
    if (w == 0 || h == 0) return;
    bpl = (w + 7) / 8;
    // out-of-range codes and code zero fall back to the first glyph
    idx = (code != 0 && 32'(code) < 32'(regs.glyph_count)) ? 32'(code) : 32'd0;
    glyph = 32'(regs.header_bytes) + idx * 32'(regs.glyph_bytes);
    origin = regs.fb_base + 32'(cy) * h * 32'(regs.line_pitch) + 32'(cx) * w * 32'd4;
    for (y = 0; y < h; y++) begin
      left = w;
      for (b = 0; b < bpl; b++) begin
        row = font_copy[15'(glyph + y * bpl + b)];
        cnt = (left > 8) ? 32'd8 : left;
        s.address = origin + y * 32'(regs.line_pitch) + b * 32'd32;
        s.count = cnt[3:0];
        // msb first; pixels past the count read as zero
        for (k = 0; k < 8; k++) begin
          s.color[k] = (k < cnt) ? (row[7 - k] ? fg : bg) : 32'd0;
        end
        s.last = (y + 1 == h) && (b + 1 == bpl);
        segment_q.push_back(s);
        left = left - cnt;
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  // track register writes, store loads and draw requests; check each accepted segment
  always @(posedge clk) begin : watch
    segment_t         want;
    logic [7:0][31:0] got_color;
    int unsigned      k;
    if (rst) begin
      regs.glyph_width  = RST_GLYPH_WIDTH;
      regs.glyph_height = RST_GLYPH_HEIGHT;
      regs.glyph_count  = RST_GLYPH_COUNT;
      regs.glyph_bytes  = RST_GLYPH_BYTES;
      regs.header_bytes = RST_HEADER_BYTES;
      regs.line_pitch   = RST_LINE_PITCH;
      regs.fb_base      = RST_FB_BASE;
      segment_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GLYPH_WIDTH:  regs.glyph_width  = cfg_data[4:0];
          REG_GLYPH_HEIGHT: regs.glyph_height = cfg_data[5:0];
          REG_GLYPH_COUNT:  regs.glyph_count  = cfg_data[9:0];
          REG_GLYPH_BYTES:  regs.glyph_bytes  = cfg_data[6:0];
          REG_HEADER_BYTES: regs.header_bytes = cfg_data[7:0];
          REG_LINE_PITCH:   regs.line_pitch   = cfg_data[15:0];
          REG_FB_BASE:      regs.fb_base      = cfg_data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        if (cmd.mode == MODE_LOAD) begin
          font_copy[cmd.store_address] = cmd.store_byte;
        end else begin
          expand_glyph(cmd.char_code, cmd.cell_x, cmd.cell_y, cmd.fg_color, cmd.bg_color);
        end
      end
      if (pixels.valid && pixels.ready) begin
        if (segment_q.size() == 0) begin
          $error("segment at address %h with no request waiting", pixels.pixel_address);
          mismatches++;
        end else begin
          want = segment_q.pop_front();
          got_color = {pixels.color_7, pixels.color_6, pixels.color_5, pixels.color_4,
                       pixels.color_3, pixels.color_2, pixels.color_1, pixels.color_0};
          check_field("pixel_address", want.address, pixels.pixel_address);
          check_field("pixel_count", 32'(want.count), 32'(pixels.pixel_count));
          for (k = 0; k < 8; k++) begin
            check_field($sformatf("color_%0d", k), want.color[k], got_color[k]);
          end
          check_field("last_segment", 32'(want.last), 32'(pixels.last_segment));
        end
      end
    end
    pending = segment_q.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench top for the bitmap glyph blitter: clock, reset, register phases, load and
// draw requests, segment back-pressure and verdict; depends on bgb_pkg, bgb_tb_pkg,
// the channel interfaces, glyph_segment_checker and bitmap_glyph_blitter
module tb;
  import bgb_pkg::*;
  import bgb_tb_pkg::*;

  // the run limit leaves many times the slowest legal run (every draw at 64 segments, every
  // hold-off at the longest gap, every staged glyph at 64 bytes)
  localparam int unsigned CYCLE_LIMIT   = 3000000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RANDOM_PHASES = 2;
  localparam int unsigned PHASE_ITEMS   = 6;
  localparam int unsigned POOL_SIZE     = 2;
  localparam logic [7:0][7:0] ROW_PATTERN = {8'h55, 8'hAA, 8'h18, 8'h24,
                                             8'h42, 8'h81, 8'hFF, 8'h00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycles = 0;
  int          send_run = 0;
  int          take_run = 0;
  bit          written [STORE_DEPTH];
  cfg_t        shadow;

  bgb_in_if  cmd ();
  bgb_out_if pixels ();

  bitmap_glyph_blitter dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .pixels    (pixels)
  );

  glyph_segment_checker chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .pixels     (pixels),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // idle cycles before the next transfer; now and then a burst with no idling
  function automatic int next_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [7:0] pick_row();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // segment back-pressure: ready can drop for a random stretch before each segment
  initial begin : segment_sink
    int gap;
    pixels.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      gap = next_gap(take_run);
      if (gap != 0) begin
        pixels.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pixels.ready <= 1'b1;
      @(posedge clk);
      while (!(pixels.valid && pixels.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // one request; entered and left at a falling edge
  task automatic send_request(input logic mode, input logic [15:0] code,
                              input logic [9:0] cx, input logic [9:0] cy,
                              input logic [31:0] fg, input logic [31:0] bg,
                              input logic [14:0] addr, input logic [7:0] data);
    int gap;
    gap = next_gap(send_run);
    if (gap != 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.mode          <= mode;
    cmd.char_code     <= code;
    cmd.cell_x        <= cx;
    cmd.cell_y        <= cy;
    cmd.fg_color      <= fg;
    cmd.bg_color      <= bg;
    cmd.store_address <= addr;
    cmd.store_byte    <= data;
    cmd.valid         <= 1'b1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    @(negedge clk);
    if (mode == MODE_LOAD) written[addr] = 1'b1;
  endtask

  task automatic load_byte(input logic [14:0] addr, input logic [7:0] data);
    send_request(MODE_LOAD, 16'($urandom), 10'($urandom), 10'($urandom), $urandom,
                 $urandom, addr, data);
  endtask

  // fill every store byte the glyph will read that has never been loaded
  task automatic stage_glyph(input logic [15:0] code);
    int unsigned w, h, idx, first, i;
    logic [14:0] a;
    w = (shadow.glyph_width > GLYPH_MAX_WIDTH) ? GLYPH_MAX_WIDTH : shadow.glyph_width;
    h = (shadow.glyph_height > GLYPH_MAX_HEIGHT) ? GLYPH_MAX_HEIGHT : shadow.glyph_height;
    if (w == 0 || h == 0) return;
    idx = (code != 0 && code < shadow.glyph_count) ? code : 0;
    first = shadow.header_bytes + idx * shadow.glyph_bytes;
    for (i = 0; i < h * ((w + 7) / 8); i++) begin
      a = 15'(first + i);
      if (!written[a]) load_byte(a, pick_row());
    end
  endtask

  task automatic draw_char(input logic [15:0] code, input logic [9:0] cx,
                           input logic [9:0] cy, input logic [31:0] fg,
                           input logic [31:0] bg);
    stage_glyph(code);
    send_request(MODE_DRAW, code, cx, cy, fg, bg, 15'($urandom), 8'($urandom));
  endtask

  task automatic draw_random(input logic [15:0] code);
    draw_char(code, 10'($urandom), 10'($urandom), $urandom, $urandom);
  endtask

  // hold requests until every segment is back and the pipeline has gone quiet
  task automatic drain();
    cmd.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // new register setting; junk above each field's width when asked
  task automatic set_config(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] count, input logic [31:0] bytes,
                            input logic [31:0] hdr, input logic [31:0] pitch,
                            input logic [31:0] base, input bit noisy);
    logic [31:0] junk;
    junk = noisy ? $urandom : 32'd0;
    drain();
    write_reg(REG_GLYPH_WIDTH, {junk[31:5], w[4:0]});
    write_reg(REG_GLYPH_HEIGHT, {junk[31:6], h[5:0]});
    write_reg(REG_GLYPH_COUNT, {junk[31:10], count[9:0]});
    write_reg(REG_GLYPH_BYTES, {junk[31:7], bytes[6:0]});
    write_reg(REG_HEADER_BYTES, {junk[31:8], hdr[7:0]});
    write_reg(REG_LINE_PITCH, {junk[31:16], pitch[15:0]});
    write_reg(REG_FB_BASE, base);
    cfg_write <= 1'b0;
    shadow.glyph_width  = w[4:0];
    shadow.glyph_height = h[5:0];
    shadow.glyph_count  = count[9:0];
    shadow.glyph_bytes  = bytes[6:0];
    shadow.header_bytes = hdr[7:0];
    shadow.line_pitch   = pitch[15:0];
    shadow.fb_base      = base;
  endtask

  function automatic logic [31:0] pick_size(input int unsigned max_size,
                                            input int unsigned field_max);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return $urandom_range(max_size + 1, field_max);
      2, 3:    return max_size;
      default: return $urandom_range(1, max_size);
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] pool [POOL_SIZE];
    int unsigned i, p, r;
    cmd.valid         = 1'b0;
    cmd.mode          = MODE_LOAD;
    cmd.char_code     = '0;
    cmd.cell_x        = '0;
    cmd.cell_y        = '0;
    cmd.fg_color      = '0;
    cmd.bg_color      = '0;
    cmd.store_address = '0;
    cmd.store_byte    = '0;
    cfg_write         = 1'b0;
    cfg_index         = REG_GLYPH_WIDTH;
    cfg_data          = '0;
    shadow.glyph_width  = RST_GLYPH_WIDTH;
    shadow.glyph_height = RST_GLYPH_HEIGHT;
    shadow.glyph_count  = RST_GLYPH_COUNT;
    shadow.glyph_bytes  = RST_GLYPH_BYTES;
    shadow.header_bytes = RST_HEADER_BYTES;
    shadow.line_pitch   = RST_LINE_PITCH;
    shadow.fb_base      = RST_FB_BASE;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: store ends, a hand-drawn glyph, color and position extremes
    load_byte(15'h7FFF, 8'hFF);
    load_byte(15'h0000, 8'h00);
    for (i = 0; i < 16; i++) begin
      load_byte(15'(RST_HEADER_BYTES + 65 * RST_GLYPH_BYTES + i), ROW_PATTERN[i[2:0]]);
    end
    draw_char(16'd65, 10'd0, 10'd0, 32'hFFFF_FFFF, 32'h0);
    draw_char(16'd65, 10'd1023, 10'd1023, 32'h0, 32'hFFFF_FFFF);
    // code zero, codes just below, at and past the glyph count
    draw_random(16'd0);
    draw_random(16'hFFFF);
    draw_random(16'd255);
    draw_random(16'd256);

    // largest glyph, farthest glyph, address wrap past the top of the framebuffer
    set_config(16, 32, 512, 64, 255, 65535, 32'hFFFF_FFF0, 1'b0);
    draw_char(16'd511, 10'd1023, 10'd1023, 32'hFFFF_FFFF, 32'h0);

    // smallest glyph, no header, zero pitch
    set_config(1, 1, 1, 1, 0, 0, 0, 1'b0);
    draw_random(16'd0);
    draw_random(16'd1);
    draw_random(16'hFFFF);

    // width and height past their limits saturate; zero glyph count
    // glyph 0 lands on the bytes the farthest glyph wrapped onto
    set_config(31, 63, 0, 127, 191, $urandom, $urandom, 1'b1);
    draw_random(16'd5);
    draw_random(16'd0);

    // partial second byte in each row
    set_config(9, 8, 300, 20, 17, $urandom, $urandom, 1'b0);
    draw_random(16'd299);
    draw_random(16'd300);

    // zero width, then zero height: draws give nothing
    set_config(0, 16, 256, 16, 32, 4096, 0, 1'b0);
    draw_random(16'd65);
    set_config(8, 0, 256, 16, 32, 4096, 0, 1'b0);
    draw_random(16'd65);

    // random settings, each with a small working set of glyphs plus noise
    for (p = 0; p < RANDOM_PHASES; p++) begin
      set_config(pick_size(GLYPH_MAX_WIDTH, 31), pick_size(GLYPH_MAX_HEIGHT, 63),
                 $urandom_range(0, 1023), $urandom_range(0, 127), $urandom_range(0, 255),
                 $urandom, $urandom, 1'b1);
      for (i = 0; i < POOL_SIZE; i++) begin
        pool[i] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                : 16'($urandom_range(0, 600));
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          load_byte(15'($urandom), pick_row());
        end else if (r < 22) begin
          draw_random(16'($urandom));
        end else begin
          draw_random(pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
      end
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
